// File: hw/rtl/bht_pkg.sv
// Package: shared types and codes for the block heat tracker.
`timescale 1ns / 1ps
package bht_pkg;
  localparam logic [2:0] ACT_ACCESS = 3'd0;
  localparam logic [2:0] ACT_DECAY  = 3'd1;
  localparam logic [2:0] ACT_QUERY  = 3'd2;
  localparam logic [2:0] ACT_HOT    = 3'd3;
  localparam logic [2:0] ACT_COLD   = 3'd4;
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NF    = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;
  localparam logic [1:0] REG_DECAY = 2'd0;
  localparam logic [1:0] REG_HOT   = 2'd1;
  localparam logic [1:0] REG_COLD  = 2'd2;
  localparam int MAX_RESULTS = 32;
  typedef struct packed {
    logic [31:0] total;
    logic [31:0] recent;
    logic [63:0] tm;
    logic        hot;
  } slot_t;
endpackage

// File: hw/rtl/block_heat_tracker_top.sv
// Top level: block heat tracker with tag registers and one slot-data memory.
//  channel | signals                         | direction
//  command | start, busy, action, blk_id..   | in
//  result  | valid, status .. last           | out, one cycle, no stall
//  config  | psel penable pwrite paddr ..    | APB, pready tied high
// Access: tag match, memory read, then write and result; a full table answers from the tag match.
// Query: tag match then memory read on a hit; a miss answers from the tag match.
// Decay and lists: a walk over all entries, one memory read a cycle, then a final result.
// Reset clears valid bits at once; memory contents are only used for valid entries.
// busy is high while an item is in flight; results cannot be stalled.
`timescale 1ns / 1ps
module block_heat_tracker_top import bht_pkg::*; #(
  parameter int ENTRIES = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  action,
  input  logic [63:0] blk_id,
  input  logic [63:0] timestamp,
  output logic        valid,
  output logic [1:0]  status,
  output logic [63:0] block_id_out,
  output logic [31:0] total_count,
  output logic [31:0] recent_count,
  output logic [63:0] last_time,
  output logic        hot_mark,
  output logic        last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(MAX_RESULTS + 1);

  typedef enum logic [2:0] {S_IDLE, S_MATCH, S_RD, S_UPD, S_WALK, S_FIN} st_t;
  st_t state;

  logic [8:0]  decay_factor;
  logic [31:0] hot_threshold, cold_threshold;
  logic [ENTRIES-1:0] slot_valid;
  logic [63:0] slot_tag [ENTRIES];
  slot_t mem [ENTRIES];
  slot_t rd;
  logic [IW-1:0] raddr, waddr;
  logic          we;
  slot_t         wd;

  logic [2:0]  act;
  logic [63:0] id, ts;
  logic [IW-1:0] sel, walk;
  logic [IW:0]   walk_cnt;
  logic          hit, rd_ok;
  logic [IW-1:0] rd_idx;
  logic [CW-1:0] nres;
  logic          pend;
  logic [IW-1:0] pend_idx;
  slot_t         pend_d;
  logic [8:0]    f;

  // tag match and free search over flip-flop tags
  logic [ENTRIES-1:0] match;
  logic [IW-1:0] match_idx, free_idx;
  logic match_any, free_any;
  always_comb begin
    match_idx = '0; free_idx = '0; match_any = 1'b0; free_any = 1'b0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      match[i] = slot_valid[i] && (slot_tag[i] == id);
      if (match[i]) begin match_idx = IW'(i); match_any = 1'b1; end
      if (!slot_valid[i]) begin free_idx = IW'(i); free_any = 1'b1; end
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wd;
    rd <= mem[raddr];
  end

  assign pready = 1'b1;
  always_comb begin
    case (paddr[3:2])
      REG_DECAY: prdata = {23'd0, decay_factor};
      REG_HOT:   prdata = hot_threshold;
      REG_COLD:  prdata = cold_threshold;
      default:   prdata = '0;
    endcase
  end

  assign busy = (state != S_IDLE);
  assign f = (decay_factor > 9'd256) ? 9'd256 : decay_factor;

  // walk stage helpers
  slot_t dec;
  logic [40:0] prod;
  logic        lmatch;
  always_comb begin
    prod = {9'd0, rd.recent} * {32'd0, f};
    dec = rd;
    dec.recent = prod[39:8];
    dec.hot = (prod[39:8] >= hot_threshold);
    if (act == ACT_HOT) lmatch = rd.hot;
    else lmatch = !rd.hot && (rd.recent < cold_threshold);
    lmatch = lmatch && slot_valid[rd_idx];
  end

  always_comb begin
    raddr = (state == S_WALK) ? walk : sel;
    if (state == S_MATCH) raddr = match_idx;
    we = 1'b0; waddr = rd_idx; wd = dec;
    if (state == S_UPD) begin
      we = 1'b1; waddr = sel;
      wd.total = hit ? ((rd.total == '1) ? rd.total : rd.total + 32'd1) : 32'd1;
      wd.recent = hit ? ((rd.recent == '1) ? rd.recent : rd.recent + 32'd1) : 32'd1;
      wd.tm = ts;
      wd.hot = hit ? rd.hot : 1'b0;
    end else if (state == S_WALK && rd_ok && act == ACT_DECAY && slot_valid[rd_idx]) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    valid <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      slot_valid <= '0;
      decay_factor <= 9'd128;
      hot_threshold <= 32'd100;
      cold_threshold <= 32'd10;
      pend <= 1'b0;
    end else begin
      if (psel && penable && pwrite) begin
        case (paddr[3:2])
          REG_DECAY: decay_factor <= pwdata[8:0];
          REG_HOT:   hot_threshold <= pwdata;
          REG_COLD:  cold_threshold <= pwdata;
          default: ;
        endcase
      end
      case (state)
        S_IDLE: if (start) begin
          act <= action; id <= blk_id; ts <= timestamp;
          walk <= '0; walk_cnt <= '0; rd_ok <= 1'b0; nres <= '0; pend <= 1'b0;
          if (action == ACT_ACCESS || action == ACT_QUERY) state <= S_MATCH;
          else if (action == ACT_DECAY || action == ACT_HOT || action == ACT_COLD)
            state <= S_WALK;
        end
        S_MATCH: begin
          hit <= match_any;
          sel <= match_any ? match_idx : free_idx;
          if (act == ACT_QUERY && !match_any) begin
            valid <= 1'b1; status <= ST_NF; block_id_out <= '0; total_count <= '0;
            recent_count <= '0; last_time <= '0; hot_mark <= 1'b0; last <= 1'b1;
            state <= S_IDLE;
          end else if (act == ACT_ACCESS && !match_any && !free_any) begin
            valid <= 1'b1; status <= ST_FULL; block_id_out <= id; total_count <= '0;
            recent_count <= '0; last_time <= '0; hot_mark <= 1'b0; last <= 1'b1;
            state <= S_IDLE;
          end else state <= S_RD;
        end
        S_RD: begin
          if (act == ACT_QUERY) begin
            valid <= 1'b1; status <= ST_OK; block_id_out <= id; total_count <= rd.total;
            recent_count <= rd.recent; last_time <= rd.tm; hot_mark <= rd.hot;
            last <= 1'b1; state <= S_IDLE;
          end else state <= S_UPD;
        end
        S_UPD: begin
          slot_valid[sel] <= 1'b1; slot_tag[sel] <= id;
          valid <= 1'b1; status <= ST_OK; block_id_out <= id; total_count <= wd.total;
          recent_count <= wd.recent; last_time <= wd.tm; hot_mark <= wd.hot;
          last <= 1'b1; state <= S_IDLE;
        end
        S_WALK: begin
          rd_ok <= (walk_cnt < (IW+1)'(ENTRIES));
          rd_idx <= walk;
          walk <= walk + IW'(1);
          walk_cnt <= walk_cnt + (IW+1)'(1);
          if (rd_ok && act != ACT_DECAY && lmatch && nres < CW'(MAX_RESULTS)) begin
            if (pend) begin
              valid <= 1'b1; status <= ST_OK; block_id_out <= slot_tag[pend_idx];
              total_count <= pend_d.total; recent_count <= pend_d.recent;
              last_time <= pend_d.tm; hot_mark <= pend_d.hot; last <= 1'b0;
            end
            pend <= 1'b1; pend_idx <= rd_idx; pend_d <= rd; nres <= nres + CW'(1);
          end
          if (walk_cnt == (IW+1)'(ENTRIES)) state <= S_FIN;
        end
        S_FIN: begin
          valid <= 1'b1; last <= 1'b1; state <= S_IDLE;
          if (act == ACT_DECAY || !pend) begin
            status <= (act == ACT_DECAY) ? ST_OK : ST_EMPTY;
            block_id_out <= '0; total_count <= '0; recent_count <= '0;
            last_time <= '0; hot_mark <= 1'b0;
          end else begin
            status <= ST_OK; block_id_out <= slot_tag[pend_idx];
            total_count <= pend_d.total; recent_count <= pend_d.recent;
            last_time <= pend_d.tm; hot_mark <= pend_d.hot;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_res_busy: assert property (@(posedge clk) disable iff (rst) valid |-> $past(busy))
    else $error("result without item");
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !we) else $error("write while idle");
  a_fin_last: assert property (@(posedge clk) disable iff (rst)
    $past(state == S_FIN) |-> (valid && last)) else $error("walk end without last");
endmodule
